FILE: design/hop_limited_bfs_reach_defines.svh
// ----------------------------------------------------------------------------
// hop limited bfs reach assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HOP_LIMITED_BFS_REACH_DEFINES_SVH
`define HOP_LIMITED_BFS_REACH_DEFINES_SVH

`ifndef SYNTHESIS
`define HLBR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HLBR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HLBR_ASSERT(label, prop, msg)
`define HLBR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: design/hlbr_pkg.sv
// ----------------------------------------------------------------------------
// hlbr_pkg
// shared types and constants of the hop limited reach block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hlbr_pkg;

   localparam int MAX_VIEWS_DEF  = 64;
   localparam int MAX_DEGREE_DEF = 8;

   localparam int MODE_W     = 2;
   localparam int NODE_W     = 6;
   localparam int MASK_W     = 64;
   localparam int DEG_W_MAX  = 7;
   localparam int TAB_AW_MAX = 12;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_POP,
      ST_QWAIT,
      ST_DEG,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                  deg_rd_en;
      logic [NODE_W-1:0]     deg_rd_addr;
      logic                  deg_wr_en;
      logic [NODE_W-1:0]     deg_wr_addr;
      logic [DEG_W_MAX-1:0]  deg_wr_data;
      logic                  clr;
      logic                  tab_rd_en;
      logic [TAB_AW_MAX-1:0] tab_rd_addr;
      logic                  tab_wr_en;
      logic [TAB_AW_MAX-1:0] tab_wr_addr;
      logic [NODE_W-1:0]     tab_wr_data;
   } store_req_type;

   typedef struct packed {
      logic [DEG_W_MAX-1:0] deg_cnt;
      logic [NODE_W-1:0]    tab_data;
   } store_rsp_type;

endpackage

FILE: design/hop_limited_bfs_reach.sv
// ----------------------------------------------------------------------------
// hop_limited_bfs_reach
// hop limited breadth-first reach over a stored adjacency table
// ----------------------------------------------------------------------------
// req channel: tuser carries the mode (append, clear, query), tdata carries
// node, neighbour and hop limit. rsp channel returns one item per query: the
// 64-bit reached mask and the overflow flag. appends and clears give no item.
// an append reads the degree, then writes the table and the degree. a
// clear is done from idle and mode 3 is dropped. during a query the
// single neighbour table read port walks one list entry per cycle and
// sets the pace until the item is loaded in the output register.
// req_tready is high only while the sequencer is idle, one item at a time.
// a finished result sits in the output register; appends and clears are
// still taken while it waits, and a following query holds at its end until
// rsp_tready frees the register. reset empties all lists, clears the
// overflow flag and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hop_limited_bfs_reach_defines.svh"

module hop_limited_bfs_reach #(
   parameter int MAX_VIEWS  = hlbr_pkg::MAX_VIEWS_DEF,
   parameter int MAX_DEGREE = hlbr_pkg::MAX_DEGREE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // node [5:0], neighbour [11:6], hop_limit [17:12], zero [23:18]
   input  logic [hlbr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode [1:0]
   input  logic [hlbr_pkg::MODE_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // reached_mask [63:0], list_overflow [64], zero [71:65]
   output logic [hlbr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int NW = hlbr_pkg::NODE_W;

   hlbr_pkg::store_req_type     st_req;
   hlbr_pkg::store_rsp_type     st_rsp;
   logic [hlbr_pkg::MASK_W-1:0] reached_mask;
   logic                        list_overflow;

   hlbr_walk #(
      .MAX_VIEWS  (MAX_VIEWS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_walk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_mode          (req_tuser),
      .req_node          (req_tdata[NW-1:0]),
      .req_neighbour     (req_tdata[2*NW-1:NW]),
      .req_hop_limit     (req_tdata[3*NW-1:2*NW]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_reached_mask  (reached_mask),
      .rsp_list_overflow (list_overflow),
      .st_req            (st_req),
      .st_rsp            (st_rsp)
   );

   hlbr_store #(
      .MAX_VIEWS  (MAX_VIEWS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .st_req (st_req),
      .st_rsp (st_rsp)
   );

   assign rsp_tdata = hlbr_pkg::RSP_TDATA_W'({list_overflow, reached_mask});

   `HLBR_ASSERT(a_deg_read_busy, st_req.deg_rd_en |=> !req_tready, "degree read while idle")
   `HLBR_ASSERT(a_result_then_idle, $rose(rsp_tvalid) |-> req_tready, "result before walk end")
   `HLBR_ASSERT(a_clear_no_write, st_req.clr |-> !st_req.deg_wr_en && !st_req.tab_wr_en, "clear with write")
   `HLBR_ASSERT_ALWAYS(a_reset_no_result, reset |=> !rsp_tvalid, "result after reset")

endmodule

FILE: design/hlbr_store.sv
// ----------------------------------------------------------------------------
// hlbr_store
// degree counters and neighbour table memories with registered reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlbr_store #(
   parameter int MAX_VIEWS  = hlbr_pkg::MAX_VIEWS_DEF,
   parameter int MAX_DEGREE = hlbr_pkg::MAX_DEGREE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hlbr_pkg::store_req_type st_req,
   output hlbr_pkg::store_rsp_type st_rsp
);

   localparam int NAW = $clog2(MAX_VIEWS);
   localparam int DCW = $clog2(MAX_DEGREE + 1);
   localparam int TAW = $clog2(MAX_VIEWS * MAX_DEGREE);

   logic [DCW-1:0]               deg_mem [MAX_VIEWS];
   logic [hlbr_pkg::NODE_W-1:0]  tab_mem [MAX_VIEWS * MAX_DEGREE];
   logic [MAX_VIEWS-1:0]         deg_vld_ff;
   logic [MAX_VIEWS-1:0]         deg_vld_in;
   logic [DCW-1:0]               deg_rd_ff;
   logic                         deg_rd_vld_ff;
   logic [hlbr_pkg::NODE_W-1:0]  tab_rd_ff;

   // valid bits stand in for a zeroed counter after reset or clear
   always_comb begin
      deg_vld_in = deg_vld_ff;
      if (st_req.clr) begin
         deg_vld_in = '0;
      end else if (st_req.deg_wr_en) begin
         deg_vld_in[st_req.deg_wr_addr[NAW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_vld_ff <= '0;
      end else begin
         deg_vld_ff <= deg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_req.deg_wr_en) begin
         deg_mem[st_req.deg_wr_addr[NAW-1:0]] <= st_req.deg_wr_data[DCW-1:0];
      end
      if (st_req.deg_rd_en) begin
         deg_rd_ff     <= deg_mem[st_req.deg_rd_addr[NAW-1:0]];
         deg_rd_vld_ff <= deg_vld_ff[st_req.deg_rd_addr[NAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (st_req.tab_wr_en) begin
         tab_mem[st_req.tab_wr_addr[TAW-1:0]] <= st_req.tab_wr_data;
      end
      if (st_req.tab_rd_en) begin
         tab_rd_ff <= tab_mem[st_req.tab_rd_addr[TAW-1:0]];
      end
   end

   assign st_rsp.deg_cnt  = deg_rd_vld_ff ? hlbr_pkg::DEG_W_MAX'(deg_rd_ff) : '0;
   assign st_rsp.tab_data = tab_rd_ff;

endmodule

FILE: design/hlbr_walk.sv
// ----------------------------------------------------------------------------
// hlbr_walk
// sequencer for appends, clears and the breadth-first walk, one entry a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlbr_walk #(
   parameter int MAX_VIEWS  = hlbr_pkg::MAX_VIEWS_DEF,
   parameter int MAX_DEGREE = hlbr_pkg::MAX_DEGREE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hlbr_pkg::MODE_W-1:0] req_mode,
   input  logic [hlbr_pkg::NODE_W-1:0] req_node,
   input  logic [hlbr_pkg::NODE_W-1:0] req_neighbour,
   input  logic [hlbr_pkg::NODE_W-1:0] req_hop_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hlbr_pkg::MASK_W-1:0] rsp_reached_mask,
   output logic                        rsp_list_overflow,
   output hlbr_pkg::store_req_type     st_req,
   input  hlbr_pkg::store_rsp_type     st_rsp
);

   localparam int NW  = hlbr_pkg::NODE_W;
   localparam int NCW = NW + 1;
   localparam int QAW = $clog2(MAX_VIEWS);
   localparam int QCW = $clog2(MAX_VIEWS + 1);
   localparam int DCW = $clog2(MAX_DEGREE + 1);
   localparam int TAW = $clog2(MAX_VIEWS * MAX_DEGREE);
   localparam int QEW = 2 * NW;

   hlbr_pkg::state_type state_ff, state_in;

   logic [NW-1:0]                node_ff, node_in;
   logic [NW-1:0]                nbr_ff, nbr_in;
   logic [NW-1:0]                limit_ff, limit_in;
   logic [NW-1:0]                cur_ff, cur_in;
   logic [NW-1:0]                depth_ff, depth_in;
   logic [DCW-1:0]               cnt_ff, cnt_in;
   logic [DCW-1:0]               k_ff, k_in;
   logic [QCW-1:0]               head_ff, head_in;
   logic [QCW-1:0]               tail_ff, tail_in;
   logic [hlbr_pkg::MASK_W-1:0]  visited_ff, visited_in;
   logic                         ovf_ff, ovf_in;
   logic                         ovf_cap_ff, ovf_cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hlbr_pkg::MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic [QEW-1:0]               q_mem [MAX_VIEWS];
   logic [QEW-1:0]               q_rd_ff;
   logic                         q_rd_en;
   logic [QAW-1:0]               q_rd_addr;
   logic                         q_wr_en;
   logic [QAW-1:0]               q_wr_addr;
   logic [QEW-1:0]               q_wr_data;

   logic [DCW-1:0]               deg_cnt;
   logic [DCW-1:0]               k_next;
   logic [TAW-1:0]               tab_base;
   logic [NW-1:0]                adj;

   assign deg_cnt  = st_rsp.deg_cnt[DCW-1:0];
   assign k_next   = k_ff + DCW'(1);
   assign adj      = st_rsp.tab_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hlbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      nbr_in       = nbr_ff;
      limit_in     = limit_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      visited_in   = visited_ff;
      ovf_in       = ovf_ff;
      ovf_cap_in   = ovf_cap_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_ready    = 1'b0;
      q_rd_en      = 1'b0;
      q_rd_addr    = head_ff[QAW-1:0];
      q_wr_en      = 1'b0;
      q_wr_addr    = tail_ff[QAW-1:0];
      q_wr_data    = '0;
      st_req       = '0;
      tab_base     = TAW'(cur_ff) * TAW'(MAX_DEGREE);

      case (state_ff)
         hlbr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (hlbr_pkg::mode_type'(req_mode))
                  hlbr_pkg::MODE_APPEND: begin
                     node_in = req_node;
                     nbr_in  = req_neighbour;
                     if (NCW'(req_node) < NCW'(MAX_VIEWS) &&
                         NCW'(req_neighbour) < NCW'(MAX_VIEWS)) begin
                        st_req.deg_rd_en   = 1'b1;
                        st_req.deg_rd_addr = req_node;
                        state_in           = hlbr_pkg::ST_APPEND;
                     end
                  end
                  hlbr_pkg::MODE_CLEAR: begin
                     st_req.clr = 1'b1;
                  end
                  hlbr_pkg::MODE_QUERY: begin
                     ovf_cap_in = ovf_ff;
                     ovf_in     = 1'b0;
                     limit_in   = req_hop_limit;
                     visited_in = '0;
                     head_in    = '0;
                     tail_in    = '0;
                     if (NCW'(req_node) < NCW'(MAX_VIEWS)) begin
                        visited_in = hlbr_pkg::MASK_W'(1) << req_node;
                        q_wr_en    = 1'b1;
                        q_wr_addr  = '0;
                        q_wr_data  = {NW'(0), req_node};
                        tail_in    = QCW'(1);
                        state_in   = hlbr_pkg::ST_POP;
                     end else begin
                        state_in   = hlbr_pkg::ST_FIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         hlbr_pkg::ST_APPEND: begin
            if (deg_cnt >= DCW'(MAX_DEGREE)) begin
               ovf_in = 1'b1;
            end else begin
               tab_base           = TAW'(node_ff) * TAW'(MAX_DEGREE);
               st_req.tab_wr_en   = 1'b1;
               st_req.tab_wr_addr = hlbr_pkg::TAB_AW_MAX'(tab_base + TAW'(deg_cnt));
               st_req.tab_wr_data = nbr_ff;
               st_req.deg_wr_en   = 1'b1;
               st_req.deg_wr_addr = node_ff;
               st_req.deg_wr_data = hlbr_pkg::DEG_W_MAX'(deg_cnt + DCW'(1));
            end
            state_in = hlbr_pkg::ST_IDLE;
         end
         hlbr_pkg::ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = hlbr_pkg::ST_FIN;
            end else begin
               q_rd_en  = 1'b1;
               head_in  = head_ff + QCW'(1);
               state_in = hlbr_pkg::ST_QWAIT;
            end
         end
         hlbr_pkg::ST_QWAIT: begin
            cur_in   = q_rd_ff[NW-1:0];
            depth_in = q_rd_ff[QEW-1:NW];
            if (q_rd_ff[QEW-1:NW] >= limit_ff) begin
               state_in = hlbr_pkg::ST_POP;
            end else begin
               st_req.deg_rd_en   = 1'b1;
               st_req.deg_rd_addr = q_rd_ff[NW-1:0];
               state_in           = hlbr_pkg::ST_DEG;
            end
         end
         hlbr_pkg::ST_DEG: begin
            cnt_in = deg_cnt;
            k_in   = '0;
            if (deg_cnt == '0) begin
               state_in = hlbr_pkg::ST_POP;
            end else begin
               st_req.tab_rd_en   = 1'b1;
               st_req.tab_rd_addr = hlbr_pkg::TAB_AW_MAX'(tab_base);
               state_in           = hlbr_pkg::ST_SCAN;
            end
         end
         hlbr_pkg::ST_SCAN: begin
            if (NCW'(adj) < NCW'(MAX_VIEWS) && !visited_ff[adj]) begin
               visited_in = visited_ff | (hlbr_pkg::MASK_W'(1) << adj);
               if (tail_ff < QCW'(MAX_VIEWS)) begin
                  q_wr_en   = 1'b1;
                  q_wr_data = {depth_ff + NW'(1), adj};
                  tail_in   = tail_ff + QCW'(1);
               end
            end
            if (k_next < cnt_ff) begin
               st_req.tab_rd_en   = 1'b1;
               st_req.tab_rd_addr = hlbr_pkg::TAB_AW_MAX'(tab_base + TAW'(k_next));
               k_in               = k_next;
            end else begin
               state_in = hlbr_pkg::ST_POP;
            end
         end
         hlbr_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = visited_ff;
               rsp_ovf_in   = ovf_cap_ff;
               state_in     = hlbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hlbr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      nbr_ff      <= nbr_in;
      limit_ff    <= limit_in;
      cur_ff      <= cur_in;
      depth_ff    <= depth_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      visited_ff  <= visited_in;
      ovf_cap_ff  <= ovf_cap_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // walk queue of {depth, node}
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         q_mem[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         q_rd_ff <= q_mem[q_rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reached_mask  = rsp_mask_ff;
   assign rsp_list_overflow = rsp_ovf_ff;

endmodule
